// ----- src/osc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osc_pkg
// Shared types and constants of the output script classifier: widths, script
// opcodes, template lengths, class codes and the item and result records.
// ----------------------------------------------------------------------------
package osc_pkg;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 14;
  localparam int TYPE_W  = 4;
  localparam int OFS_W   = 2;
  localparam int COUNT_W = 5;

  // Default upper bound on the script length.
  localparam int MAX_SCRIPT_BYTES_DFLT = 10000;

  // Class codes.
  localparam logic [TYPE_W-1:0] TYPE_NONSTD   = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_OPRETURN = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_P2PK33   = 4'd2;
  localparam logic [TYPE_W-1:0] TYPE_P2PK65   = 4'd3;
  localparam logic [TYPE_W-1:0] TYPE_P2PKH    = 4'd4;
  localparam logic [TYPE_W-1:0] TYPE_P2SH     = 4'd5;
  localparam logic [TYPE_W-1:0] TYPE_P2WPKH   = 4'd6;
  localparam logic [TYPE_W-1:0] TYPE_P2WSH    = 4'd7;
  localparam logic [TYPE_W-1:0] TYPE_P2TR     = 4'd8;
  localparam logic [TYPE_W-1:0] TYPE_MULTISIG = 4'd9;

  // Script opcodes and push lengths.
  localparam logic [BYTE_W-1:0] OP_0               = 8'h00;
  localparam logic [BYTE_W-1:0] PUSH_LEN20         = 8'h14;
  localparam logic [BYTE_W-1:0] PUSH_LEN32         = 8'h20;
  localparam logic [BYTE_W-1:0] PUSH_LEN33         = 8'h21;
  localparam logic [BYTE_W-1:0] PUSH_LEN65         = 8'h41;
  localparam logic [BYTE_W-1:0] OP_1               = 8'h51;
  localparam logic [BYTE_W-1:0] OP_16              = 8'h60;
  localparam logic [BYTE_W-1:0] OP_SMALLINT_BASE   = 8'h50;
  localparam logic [BYTE_W-1:0] OP_NULL_DATA       = 8'h6A;
  localparam logic [BYTE_W-1:0] OP_DUP             = 8'h76;
  localparam logic [BYTE_W-1:0] OP_EQ_CHECK        = 8'h87;
  localparam logic [BYTE_W-1:0] OP_EQ_VERIFY       = 8'h88;
  localparam logic [BYTE_W-1:0] OP_HASH20          = 8'hA9;
  localparam logic [BYTE_W-1:0] OP_SIG_CHECK       = 8'hAC;
  localparam logic [BYTE_W-1:0] OP_MULTI_SIG_CHECK = 8'hAE;

  // Whole-script lengths of the fixed templates.
  localparam logic [LEN_W-1:0] LEN_P2PK33       = 14'd35;
  localparam logic [LEN_W-1:0] LEN_P2PK65       = 14'd67;
  localparam logic [LEN_W-1:0] LEN_P2PKH        = 14'd25;
  localparam logic [LEN_W-1:0] LEN_P2SH         = 14'd23;
  localparam logic [LEN_W-1:0] LEN_P2WPKH       = 14'd22;
  localparam logic [LEN_W-1:0] LEN_WITNESS32    = 14'd34;
  localparam logic [LEN_W-1:0] LEN_MULTISIG_MIN = 14'd37;

  // One script byte request.
  typedef struct packed {
    logic [BYTE_W-1:0] script_byte;
    logic              is_last;
    logic              empty_script;
  } item_t;

  // One classification result.
  typedef struct packed {
    logic [TYPE_W-1:0]  type_code;
    logic [OFS_W-1:0]   payload_offset;
    logic [LEN_W-1:0]   payload_length;
    logic [LEN_W-1:0]   script_length;
    logic               too_long;
    logic [COUNT_W-1:0] sigs_required;
    logic [COUNT_W-1:0] keys_total;
  } result_t;

endpackage

// ----- src/osc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osc_in_if / osc_out_if
// Valid/ready channels of the output script classifier: script bytes in,
// classification results out.
// ----------------------------------------------------------------------------
interface osc_in_if;
  import osc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] script_byte;
  logic              is_last;
  logic              empty_script;

  modport source (output valid, output script_byte, output is_last,
                  output empty_script, input ready);
  modport sink (input valid, input script_byte, input is_last,
                input empty_script, output ready);
endinterface

interface osc_out_if;
  import osc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  type_code;
  logic [OFS_W-1:0]   payload_offset;
  logic [LEN_W-1:0]   payload_length;
  logic [LEN_W-1:0]   script_length;
  logic               too_long;
  logic [COUNT_W-1:0] sigs_required;
  logic [COUNT_W-1:0] keys_total;

  modport source (output valid, output type_code, output payload_offset,
                  output payload_length, output script_length, output too_long,
                  output sigs_required, output keys_total, input ready);
  modport sink (input valid, input type_code, input payload_offset,
                input payload_length, input script_length, input too_long,
                input sigs_required, input keys_total, output ready);
endinterface

// ----- src/osc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osc_core
// Per-script state of the classifier. Each stepped byte updates the position,
// the template match flags, the first and last two bytes and the multisig push
// walk; the ending request also produces the classification and clears state.
// ----------------------------------------------------------------------------
module osc_core #(
  parameter int MAX_SCRIPT_BYTES = osc_pkg::MAX_SCRIPT_BYTES_DFLT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  osc_pkg::item_t  item,
  output logic            res_valid,
  output osc_pkg::result_t res
);
  import osc_pkg::*;

  // Bits of the template match flags.
  localparam int F_PK33    = 0;
  localparam int F_PK65    = 1;
  localparam int F_PKH     = 2;
  localparam int F_SH      = 3;
  localparam int F_WPKH    = 4;
  localparam int F_WSH     = 5;
  localparam int F_TR      = 6;
  localparam int F_INRANGE = 7;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SCRIPT_BYTES);

  // Current state.
  logic [LEN_W-1:0]    pos;
  logic [7:0]          flags;
  logic [BYTE_W-1:0]   first_byte;
  logic [15:0]         last_two;
  logic [LEN_W-1:0]    next_push;
  logic [3:0]          pending;
  logic                bad_push;
  logic [COUNT_W-1:0]  key_count;

  // State after this byte.
  logic [LEN_W-1:0]    pos_next;
  logic [7:0]          flags_next;
  logic [BYTE_W-1:0]   first_byte_next;
  logic [15:0]         last_two_next;
  logic [LEN_W-1:0]    next_push_next;
  logic [3:0]          pending_next;
  logic                bad_push_next;
  logic [COUNT_W-1:0]  key_count_next;

  logic ends;

  assign ends      = item.empty_script | item.is_last;
  assign res_valid = step & ends;

  // Byte update: templates, first byte and the multisig push walk.
  always_comb begin
    logic [BYTE_W-1:0] b;
    logic [1:0]        old;
    logic [1:0]        mark;
    logic [LEN_W:0]    nx;

    b               = item.script_byte;
    old             = pending[3:2];
    mark            = 2'b00;
    nx              = '0;
    pos_next        = pos;
    flags_next      = flags;
    first_byte_next = first_byte;
    last_two_next   = last_two;
    next_push_next  = next_push;
    pending_next    = pending;
    bad_push_next   = bad_push;
    key_count_next  = key_count;

    if (!item.empty_script) begin
      last_two_next = {last_two[7:0], b};
      if (pos >= MAX_LEN) begin
        flags_next[F_INRANGE] = 1'b0;
      end else begin
        if (pos == '0) begin
          first_byte_next = b;
        end
        // Fixed-layout template checks at their byte positions.
        case (pos)
          14'd0: begin
            if (b != PUSH_LEN33) flags_next[F_PK33] = 1'b0;
            if (b != PUSH_LEN65) flags_next[F_PK65] = 1'b0;
            if (b != OP_DUP) flags_next[F_PKH] = 1'b0;
            if (b != OP_HASH20) flags_next[F_SH] = 1'b0;
            if (b != OP_0) begin
              flags_next[F_WPKH] = 1'b0;
              flags_next[F_WSH]  = 1'b0;
            end
            if (b != OP_1) flags_next[F_TR] = 1'b0;
          end
          14'd1: begin
            if (b != OP_HASH20) flags_next[F_PKH] = 1'b0;
            if (b != PUSH_LEN20) begin
              flags_next[F_SH]   = 1'b0;
              flags_next[F_WPKH] = 1'b0;
            end
            if (b != PUSH_LEN32) begin
              flags_next[F_WSH] = 1'b0;
              flags_next[F_TR]  = 1'b0;
            end
          end
          14'd2: begin
            if (b != PUSH_LEN20) flags_next[F_PKH] = 1'b0;
          end
          14'd22: begin
            if (b != OP_EQ_CHECK) flags_next[F_SH] = 1'b0;
          end
          14'd23: begin
            if (b != OP_EQ_VERIFY) flags_next[F_PKH] = 1'b0;
          end
          14'd24: begin
            if (b != OP_SIG_CHECK) flags_next[F_PKH] = 1'b0;
          end
          14'd34: begin
            if (b != OP_SIG_CHECK) flags_next[F_PK33] = 1'b0;
          end
          14'd66: begin
            if (b != OP_SIG_CHECK) flags_next[F_PK65] = 1'b0;
          end
          default: begin
          end
        endcase

        // A push mark two positions back is now known to lie before the
        // closing opcode, so it counts as a key or as a bad push.
        if (old[0] && !bad_push) begin
          if (old[1]) begin
            bad_push_next = 1'b1;
          end else if (key_count != '1) begin
            key_count_next = key_count + COUNT_W'(1);
          end
        end

        // Walk from one key push to the next.
        if (pos != '0 && pos == next_push) begin
          mark[0] = 1'b1;
          if (b == PUSH_LEN33 || b == PUSH_LEN65) begin
            nx = {1'b0, pos} + (LEN_W+1)'(1) + (LEN_W+1)'(b);
            next_push_next = (nx > {1'b0, MAX_LEN}) ? MAX_LEN : nx[LEN_W-1:0];
          end else begin
            mark[1] = 1'b1;
          end
        end
        pending_next = {pending[1:0], mark};
        pos_next     = pos + LEN_W'(1);
      end
    end
  end

  // Classification from the updated state.
  always_comb begin
    logic [BYTE_W-1:0] lastb;
    logic [BYTE_W-1:0] nb;
    logic [BYTE_W-1:0] m_full;
    logic [BYTE_W-1:0] n_full;
    logic              is_multi;

    lastb  = last_two_next[7:0];
    nb     = last_two_next[15:8];
    m_full = first_byte_next - OP_SMALLINT_BASE;
    n_full = nb - OP_SMALLINT_BASE;
    is_multi = (pos_next >= LEN_MULTISIG_MIN) && (lastb == OP_MULTI_SIG_CHECK) &&
               (first_byte_next >= OP_1) && (first_byte_next <= OP_16) &&
               (nb >= OP_1) && (nb <= OP_16) && (first_byte_next <= nb) &&
               !bad_push_next && pending_next[2] &&
               (key_count_next == n_full[COUNT_W-1:0]);

    res.type_code      = TYPE_NONSTD;
    res.payload_offset = '0;
    res.payload_length = pos_next;
    res.script_length  = pos_next;
    res.too_long       = ~flags_next[F_INRANGE];
    res.sigs_required  = '0;
    res.keys_total     = '0;

    if (!flags_next[F_INRANGE]) begin
      res.type_code = TYPE_NONSTD;
    end else if (pos_next != '0 && first_byte_next == OP_NULL_DATA) begin
      res.type_code      = TYPE_OPRETURN;
      res.payload_length = '0;
    end else if (pos_next == LEN_P2PK33 && flags_next[F_PK33]) begin
      res.type_code      = TYPE_P2PK33;
      res.payload_offset = OFS_W'(1);
      res.payload_length = LEN_W'(33);
    end else if (pos_next == LEN_P2PK65 && flags_next[F_PK65]) begin
      res.type_code      = TYPE_P2PK65;
      res.payload_offset = OFS_W'(1);
      res.payload_length = LEN_W'(65);
    end else if (pos_next == LEN_P2PKH && flags_next[F_PKH]) begin
      res.type_code      = TYPE_P2PKH;
      res.payload_offset = OFS_W'(3);
      res.payload_length = LEN_W'(20);
    end else if (pos_next == LEN_P2SH && flags_next[F_SH]) begin
      res.type_code      = TYPE_P2SH;
      res.payload_offset = OFS_W'(2);
      res.payload_length = LEN_W'(20);
    end else if (pos_next == LEN_P2WPKH && flags_next[F_WPKH]) begin
      res.type_code      = TYPE_P2WPKH;
      res.payload_offset = OFS_W'(2);
      res.payload_length = LEN_W'(20);
    end else if (pos_next == LEN_WITNESS32 && flags_next[F_WSH]) begin
      res.type_code      = TYPE_P2WSH;
      res.payload_offset = OFS_W'(2);
      res.payload_length = LEN_W'(32);
    end else if (pos_next == LEN_WITNESS32 && flags_next[F_TR]) begin
      res.type_code      = TYPE_P2TR;
      res.payload_offset = OFS_W'(2);
      res.payload_length = LEN_W'(32);
    end else if (is_multi) begin
      res.type_code     = TYPE_MULTISIG;
      res.sigs_required = m_full[COUNT_W-1:0];
      res.keys_total    = n_full[COUNT_W-1:0];
    end
  end

  // State registers; the ending request returns them to the start values.
  always_ff @(posedge clk) begin
    if (rst || (step && ends)) begin
      pos        <= '0;
      flags      <= '1;
      first_byte <= '0;
      last_two   <= '0;
      next_push  <= LEN_W'(1);
      pending    <= '0;
      bad_push   <= 1'b0;
      key_count  <= '0;
    end else if (step) begin
      pos        <= pos_next;
      flags      <= flags_next;
      first_byte <= first_byte_next;
      last_two   <= last_two_next;
      next_push  <= next_push_next;
      pending    <= pending_next;
      bad_push   <= bad_push_next;
      key_count  <= key_count_next;
    end
  end

endmodule

// ----- src/output_script_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// output_script_classifier
// Sorts a transaction output script, streamed one byte per request, into a
// standard template class and reports where its payload lies.
// ----------------------------------------------------------------------------
// The block takes one script byte request in every cycle. A request is held
// in an input register, then the classifier state is updated and, on the
// request that ends a script (last byte or empty script), one result is
// written into a two-entry result buffer, whose head is shown on the result
// port. The input stalls only when a registered ending request finds both
// result buffer entries still waiting to be taken.
// Scripts longer than MAX_SCRIPT_BYTES are reported as nonstandard with the
// too_long flag set and the lengths held at the maximum.
// ----------------------------------------------------------------------------
module output_script_classifier #(
  parameter int MAX_SCRIPT_BYTES = osc_pkg::MAX_SCRIPT_BYTES_DFLT
) (
  input  logic    clk,
  input  logic    rst,
  osc_in_if.sink  script,
  osc_out_if.source result
);
  import osc_pkg::*;

  // Input register.
  logic    in_valid;
  item_t   in_item;
  logic    step;
  logic    step_ends;

  // Result buffer: head is shown on the port, tail holds a second result.
  result_t head;
  result_t tail;
  logic [1:0] count;
  logic       buf_full;
  logic       push;
  logic       pop;

  logic    core_valid;
  result_t core_res;

  assign buf_full  = (count == 2'd2);
  assign step_ends = in_item.empty_script | in_item.is_last;
  assign step      = in_valid & (~step_ends | ~buf_full);
  assign script.ready = ~in_valid | step;

  // Capture an accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (script.valid && script.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (script.valid && script.ready) begin
      in_item.script_byte  <= script.script_byte;
      in_item.is_last      <= script.is_last;
      in_item.empty_script <= script.empty_script;
    end
  end

  osc_core #(
    .MAX_SCRIPT_BYTES(MAX_SCRIPT_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (in_item),
    .res_valid(core_valid),
    .res      (core_res)
  );

  assign push = core_valid;
  assign pop  = result.valid & result.ready;

  // Result buffer occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Result buffer data.
  always_ff @(posedge clk) begin
    if (count == 2'd0 || (count == 2'd1 && pop)) begin
      if (push) head <= core_res;
    end else if (count == 2'd1) begin
      if (push) tail <= core_res;
    end else if (pop) begin
      head <= tail;
    end
  end

  assign result.valid          = (count != 2'd0);
  assign result.type_code      = head.type_code;
  assign result.payload_offset = head.payload_offset;
  assign result.payload_length = head.payload_length;
  assign result.script_length  = head.script_length;
  assign result.too_long       = head.too_long;
  assign result.sigs_required  = head.sigs_required;
  assign result.keys_total     = head.keys_total;

endmodule

// ----- src/osc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osc_checker
// Port-level checks of the output script classifier, attached by bind.
// ----------------------------------------------------------------------------
module osc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [osc_pkg::TYPE_W-1:0]  type_code,
  input logic [osc_pkg::OFS_W-1:0]   payload_offset,
  input logic [osc_pkg::LEN_W-1:0]   payload_length,
  input logic [osc_pkg::LEN_W-1:0]   script_length,
  input logic                        too_long,
  input logic [osc_pkg::COUNT_W-1:0] sigs_required,
  input logic [osc_pkg::COUNT_W-1:0] keys_total
);
  import osc_pkg::*;

  // Until taken, a waiting result stays valid and keeps its type, lengths and n.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(type_code) &&
      $stable(payload_length) && $stable(script_length) && $stable(keys_total))
    else $error("result changed while waiting");

  // Only multisig results carry m and n.
  a_counts: assert property (@(posedge clk) disable iff (rst)
    res_valid && type_code != TYPE_MULTISIG |-> sigs_required == '0 &&
      keys_total == '0)
    else $error("m or n set on a non-multisig result");

  // An over-long script is nonstandard and covers the whole script.
  a_too_long: assert property (@(posedge clk) disable iff (rst)
    res_valid && too_long |-> type_code == TYPE_NONSTD &&
      payload_length == script_length && payload_offset == '0)
    else $error("over-long script not reported as nonstandard");

  // A multisig result has a sane m of n and room for its keys.
  a_multisig: assert property (@(posedge clk) disable iff (rst)
    res_valid && type_code == TYPE_MULTISIG |-> sigs_required != '0 &&
      sigs_required <= keys_total && script_length >= LEN_MULTISIG_MIN)
    else $error("inconsistent multisig result");

endmodule

bind output_script_classifier osc_checker u_osc_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .type_code     (result.type_code),
  .payload_offset(result.payload_offset),
  .payload_length(result.payload_length),
  .script_length (result.script_length),
  .too_long      (result.too_long),
  .sigs_required (result.sigs_required),
  .keys_total    (result.keys_total)
);
